>>> sv/puf_pkg.sv
package puf_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int FIELD_W    = 10;
  localparam int ENTRY_W    = IDX_W + 1;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic OP_CONSTRAIN = 1'b0;
  localparam logic OP_CLEAR     = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    CMD_LINK,
    CMD_CLEAR,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    idx_t      a;
    idx_t      b;
    logic      rel;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_F_ISSUE,
    ST_F_WAIT,
    ST_C_ISSUE,
    ST_C_WAIT,
    ST_LINK
  } back_state_t;

endpackage

>>> sv/puf_ram.sv
module puf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/puf_front.sv
module puf_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        operation,
  input  logic [puf_pkg::FIELD_W-1:0] node_a,
  input  logic [puf_pkg::FIELD_W-1:0] node_b,
  input  logic                        relation,
  input  logic                        pop,
  output puf_pkg::q_head_t            head,
  output logic                        full
);

  puf_pkg::cmd_t                    slot [puf_pkg::QDEPTH];
  puf_pkg::cmd_t                    incoming;
  logic [puf_pkg::QPTR_W-1:0]       wr_ptr;
  logic [puf_pkg::QPTR_W-1:0]       rd_ptr;
  logic [puf_pkg::QCNT_W-1:0]       count;

  // classify the word on entry
  always_comb begin
    incoming.a   = puf_pkg::IDX_W'(node_a);
    incoming.b   = puf_pkg::IDX_W'(node_b);
    incoming.rel = relation;
    if (operation == puf_pkg::OP_CLEAR) begin
      incoming.kind = puf_pkg::CMD_CLEAR;
    end else if ((32'(node_a) >= puf_pkg::NODE_COUNT) ||
                 (32'(node_b) >= puf_pkg::NODE_COUNT)) begin
      incoming.kind = puf_pkg::CMD_REJECT;
    end else begin
      incoming.kind = puf_pkg::CMD_LINK;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == puf_pkg::QPTR_W'(puf_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == puf_pkg::QPTR_W'(puf_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd   = slot[rd_ptr];
  assign full       = (count == puf_pkg::QCNT_W'(puf_pkg::QDEPTH));

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= puf_pkg::QCNT_W'(puf_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty queue");

endmodule

>>> sv/puf_back.sv
module puf_back (
  input  logic             clk,
  input  logic             rst,
  input  puf_pkg::q_head_t head,
  output logic             pop,
  output logic             sweeping,
  output logic             done,
  output logic             consistent
);

  localparam puf_pkg::idx_t LAST_IDX = puf_pkg::IDX_W'(puf_pkg::NODE_COUNT - 1);

  puf_pkg::back_state_t         state;
  puf_pkg::back_state_t         state_next;
  puf_pkg::back_state_t         phase_end;

  puf_pkg::idx_t                sweep_idx;
  puf_pkg::idx_t                cur;
  puf_pkg::idx_t                start_node;
  puf_pkg::idx_t                root;
  puf_pkg::idx_t                root_a;
  puf_pkg::idx_t                node_b_q;
  logic                         acc;
  logic                         find_par;
  logic                         par_a;
  logic                         rel_q;
  logic                         side_b;

  logic                         we;
  puf_pkg::idx_t                waddr;
  logic [puf_pkg::ENTRY_W-1:0]  wdata;
  puf_pkg::idx_t                raddr;
  logic [puf_pkg::ENTRY_W-1:0]  rdata;
  puf_pkg::idx_t                rd_parent;
  logic                         rd_par;

  logic                         done_next;
  logic                         consistent_next;

  assign rd_parent = rdata[puf_pkg::ENTRY_W-1:1];
  assign rd_par    = rdata[0];
  assign sweeping  = (state == puf_pkg::ST_SWEEP);
  assign phase_end = side_b ? puf_pkg::ST_LINK : puf_pkg::ST_F_ISSUE;

  puf_ram #(
    .WIDTH (puf_pkg::ENTRY_W),
    .DEPTH (puf_pkg::NODE_COUNT)
  ) u_forest (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      puf_pkg::ST_IDLE: begin
        if (head.valid) begin
          case (head.cmd.kind)
            puf_pkg::CMD_CLEAR: state_next = puf_pkg::ST_SWEEP;
            puf_pkg::CMD_LINK:  state_next = puf_pkg::ST_F_ISSUE;
            default:            state_next = puf_pkg::ST_IDLE;
          endcase
        end
      end
      puf_pkg::ST_SWEEP: begin
        if (sweep_idx == LAST_IDX) state_next = puf_pkg::ST_IDLE;
      end
      puf_pkg::ST_F_ISSUE: state_next = puf_pkg::ST_F_WAIT;
      puf_pkg::ST_F_WAIT: begin
        if (rd_parent == cur) state_next = puf_pkg::ST_C_ISSUE;
      end
      puf_pkg::ST_C_ISSUE: begin
        state_next = (cur == root) ? phase_end : puf_pkg::ST_C_WAIT;
      end
      puf_pkg::ST_C_WAIT: begin
        if (rd_parent == root) state_next = phase_end;
      end
      puf_pkg::ST_LINK: state_next = puf_pkg::ST_IDLE;
      default:          state_next = puf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop             = 1'b0;
    we              = 1'b0;
    waddr           = cur;
    wdata           = {root, acc};
    raddr           = cur;
    done_next       = 1'b0;
    consistent_next = 1'b0;
    case (state)
      puf_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.cmd.kind)
            puf_pkg::CMD_CLEAR: begin
              done_next       = 1'b1;
              consistent_next = 1'b1;
            end
            puf_pkg::CMD_REJECT: begin
              done_next       = 1'b1;
              consistent_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      puf_pkg::ST_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_idx;
        wdata = {sweep_idx, 1'b0};
      end
      puf_pkg::ST_F_ISSUE: raddr = cur;
      puf_pkg::ST_F_WAIT: raddr = rd_parent;
      puf_pkg::ST_C_ISSUE: raddr = cur;
      puf_pkg::ST_C_WAIT: begin
        we    = 1'b1;
        waddr = cur;
        wdata = {root, acc};
        raddr = rd_parent;
      end
      puf_pkg::ST_LINK: begin
        done_next = 1'b1;
        if (root_a == root) begin
          consistent_next = ((par_a ^ find_par) == rel_q);
        end else begin
          we              = 1'b1;
          waddr           = root_a;
          wdata           = {root, par_a ^ find_par ^ rel_q};
          consistent_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= puf_pkg::ST_SWEEP;
      sweep_idx  <= '0;
      side_b     <= 1'b0;
      done       <= 1'b0;
      consistent <= 1'b0;
    end else begin
      state      <= state_next;
      done       <= done_next;
      consistent <= consistent_next;
      case (state)
        puf_pkg::ST_IDLE: begin
          sweep_idx <= '0;
          side_b    <= 1'b0;
        end
        puf_pkg::ST_SWEEP: sweep_idx <= sweep_idx + 1'b1;
        puf_pkg::ST_C_ISSUE: begin
          if (cur == root) side_b <= 1'b1;
        end
        puf_pkg::ST_C_WAIT: begin
          if (rd_parent == root) side_b <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      puf_pkg::ST_IDLE: begin
        cur        <= head.cmd.a;
        start_node <= head.cmd.a;
        node_b_q   <= head.cmd.b;
        rel_q      <= head.cmd.rel;
        acc        <= 1'b0;
      end
      puf_pkg::ST_F_WAIT: begin
        if (rd_parent == cur) begin
          root     <= cur;
          find_par <= acc;
          cur      <= start_node;
        end else begin
          acc <= acc ^ rd_par;
          cur <= rd_parent;
        end
      end
      puf_pkg::ST_C_ISSUE: begin
        if ((cur == root) && !side_b) begin
          root_a     <= root;
          par_a      <= find_par;
          cur        <= node_b_q;
          start_node <= node_b_q;
          acc        <= 1'b0;
        end
      end
      puf_pkg::ST_C_WAIT: begin
        if (rd_parent == root) begin
          if (!side_b) begin
            root_a     <= root;
            par_a      <= find_par;
            cur        <= node_b_q;
            start_node <= node_b_q;
            acc        <= 1'b0;
          end
        end else begin
          acc <= acc ^ rd_par;
          cur <= rd_parent;
        end
      end
      default: ;
    endcase
  end

  a_link_reports: assert property (@(posedge clk) disable iff (rst)
    (state == puf_pkg::ST_LINK) |=> done)
    else $error("link step gave no result");

  a_sweep_steps: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (state == puf_pkg::ST_SWEEP) && ($past(state) == puf_pkg::ST_SWEEP))
      |-> (sweep_idx == $past(sweep_idx) + 1'b1))
    else $error("clearing pass skipped an entry");

endmodule

>>> sv/parity_union_find_top.sv
// A clear or a rejected word is answered as it leaves the queue; a constraint
// walks the root chains of node_a and node_b, one forest RAM access per step
// of the root walk and of path compression.
// Throughput: one word at a time through the walk; a 2-entry queue takes words
// ahead. Results are a one-cycle done strobe; the receiver cannot stall.
// Reset and clear: a clearing pass over all 1024 forest entries with busy high.
module parity_union_find_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation,
  input  logic [puf_pkg::FIELD_W-1:0] node_a,
  input  logic [puf_pkg::FIELD_W-1:0] node_b,
  input  logic                        relation,
  output logic                        done,
  output logic                        consistent
);

  puf_pkg::q_head_t head;
  logic             pop;
  logic             full;
  logic             sweeping;
  logic             push;

  assign busy = full | sweeping;
  assign push = start & ~busy;

  puf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .operation (operation),
    .node_a    (node_a),
    .node_b    (node_b),
    .relation  (relation),
    .pop       (pop),
    .head      (head),
    .full      (full)
  );

  puf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .sweeping   (sweeping),
    .done       (done),
    .consistent (consistent)
  );

endmodule
